>>> rtl/imu_fd_pkg.sv
// Shared types, register map and reset values for the IMU fall detector.
// No dependencies; imported by every module of the block.
package imu_fd_pkg;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_ACC  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_RATE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_LOW   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_HIGH  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_RATE  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIM   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD        = CFG_IDX_W'(7);

    localparam logic [31:0] RST_IMPACT_ACC  = 32'd26214400;
    localparam logic [31:0] RST_IMPACT_RATE = 32'd16000000;
    localparam logic [31:0] RST_STILL_LOW   = 32'd2359296;
    localparam logic [31:0] RST_STILL_HIGH  = 32'd6553600;
    localparam logic [31:0] RST_STILL_RATE  = 32'd409600;
    localparam logic [7:0]  RST_COUNT_LIM   = 8'd10;
    localparam logic [31:0] RST_WINDOW      = 32'd3000;
    localparam logic [31:0] RST_HOLD        = 32'd10000;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [31:0]        sample_time_ms;
    } t_sample;

    typedef struct packed {
        logic       fall_flag;
        logic       impact_pending;
        logic [7:0] still_level;
    } t_result;

    typedef struct packed {
        logic [31:0] impact_acc_sq_limit;
        logic [31:0] impact_rate_sq_limit;
        logic [31:0] still_acc_sq_low;
        logic [31:0] still_acc_sq_high;
        logic [31:0] still_rate_sq_limit;
        logic [7:0]  still_count_limit;
        logic [31:0] check_window_ms;
        logic [31:0] hold_ms;
    } t_cfg;

    // classified sample handed from front to back
    typedef struct packed {
        logic        impact;
        logic        still;
        logic [31:0] now;
    } t_cls;

    typedef struct packed {
        logic valid;
        t_cls item;
    } t_qpush;

    typedef struct packed {
        logic                valid;
        t_cls                item;
        logic [QCNT_W-1:0]   count;
    } t_qhead;

endpackage

>>> rtl/imu_fd_cfg.sv
// Configuration register bank for the IMU fall detector.
// Depends on imu_fd_pkg.
module imu_fd_cfg import imu_fd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.impact_acc_sq_limit  <= RST_IMPACT_ACC;
            r_cfg.impact_rate_sq_limit <= RST_IMPACT_RATE;
            r_cfg.still_acc_sq_low     <= RST_STILL_LOW;
            r_cfg.still_acc_sq_high    <= RST_STILL_HIGH;
            r_cfg.still_rate_sq_limit  <= RST_STILL_RATE;
            r_cfg.still_count_limit    <= RST_COUNT_LIM;
            r_cfg.check_window_ms      <= RST_WINDOW;
            r_cfg.hold_ms              <= RST_HOLD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMPACT_ACC:  r_cfg.impact_acc_sq_limit  <= i_cfg_data;
                CFG_IMPACT_RATE: r_cfg.impact_rate_sq_limit <= i_cfg_data;
                CFG_STILL_LOW:   r_cfg.still_acc_sq_low     <= i_cfg_data;
                CFG_STILL_HIGH:  r_cfg.still_acc_sq_high    <= i_cfg_data;
                CFG_STILL_RATE:  r_cfg.still_rate_sq_limit  <= i_cfg_data;
                CFG_COUNT_LIM:   r_cfg.still_count_limit    <= i_cfg_data[7:0];
                CFG_WINDOW:      r_cfg.check_window_ms      <= i_cfg_data;
                CFG_HOLD:        r_cfg.hold_ms              <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/imu_fd_front.sv
// Front end: accepts samples, squares the six axes, sums and classifies.
// Depends on imu_fd_pkg; admits a beat only when the queue has room for it.
module imu_fd_front import imu_fd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_sample           i_in_data,
    input  t_cfg              i_cfg,
    input  logic [QCNT_W-1:0] i_q_count,
    output t_qpush            o_push
);

    function automatic logic [31:0] sq16(input logic signed [15:0] v);
        logic [15:0] m;
        m = v[15] ? (~v + 16'd1) : v;
        return 32'(m) * 32'(m);
    endfunction

    logic        r_v1;
    logic [31:0] r_sq [6];
    logic [31:0] r_now;
    logic [31:0] acc_sq;
    logic [31:0] rate_sq;
    logic        accept;

    assign o_in_ready = ({1'b0, i_q_count} + {{QCNT_W{1'b0}}, r_v1}) < (QCNT_W + 1)'(QDEPTH);
    assign accept     = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
        if (accept) begin
            r_sq[0] <= sq16(i_in_data.accel_x);
            r_sq[1] <= sq16(i_in_data.accel_y);
            r_sq[2] <= sq16(i_in_data.accel_z);
            r_sq[3] <= sq16(i_in_data.rate_x);
            r_sq[4] <= sq16(i_in_data.rate_y);
            r_sq[5] <= sq16(i_in_data.rate_z);
            r_now   <= i_in_data.sample_time_ms;
        end
    end

    // each sum is at most 3 * 2^30, no overflow
    assign acc_sq  = r_sq[0] + r_sq[1] + r_sq[2];
    assign rate_sq = r_sq[3] + r_sq[4] + r_sq[5];

    always_comb begin
        o_push.valid       = r_v1;
        o_push.item.now    = r_now;
        o_push.item.impact = (acc_sq > i_cfg.impact_acc_sq_limit) |
                             (rate_sq > i_cfg.impact_rate_sq_limit);
        o_push.item.still  = (acc_sq > i_cfg.still_acc_sq_low) &
                             (acc_sq < i_cfg.still_acc_sq_high) &
                             (rate_sq < i_cfg.still_rate_sq_limit);
    end

endmodule

>>> rtl/imu_fd_queue.sv
// Short queue of classified samples between front and back end.
// Depends on imu_fd_pkg; the front never pushes into a full queue.
module imu_fd_queue import imu_fd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qpush i_push,
    input  logic   i_pop,
    output t_qhead o_head
);

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign do_pop = i_pop & (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_comb begin
        o_head.valid = (r_count != '0);
        o_head.item  = r_mem[r_rd_ptr];
        o_head.count = r_count;
    end

endmodule

>>> rtl/imu_fd_back.sv
// Back end: impact / stillness state update and registered result beat.
// Depends on imu_fd_pkg; pops one classified sample per cycle when the output can take it.
module imu_fd_back import imu_fd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qhead  i_head,
    output logic    o_pop,
    input  t_cfg    i_cfg,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    logic        r_armed;
    logic        r_fall;
    logic [7:0]  r_cnt;
    logic [31:0] r_impact_time;
    logic [31:0] r_latch_time;
    logic        r_out_valid;
    t_result     r_out;

    logic        n_armed;
    logic        n_fall;
    logic [7:0]  n_cnt;
    logic [31:0] n_impact_time;
    logic [31:0] n_latch_time;
    logic        n_flag;
    logic [31:0] now;

    assign o_pop       = i_head.valid & (~r_out_valid | i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign now         = i_head.item.now;

    always_comb begin
        n_armed       = r_armed;
        n_fall        = r_fall;
        n_cnt         = r_cnt;
        n_impact_time = r_impact_time;
        n_latch_time  = r_latch_time;
        n_flag        = 1'b0;
        if (r_fall) begin
            n_flag = 1'b1;
            if ((now - r_latch_time) > i_cfg.hold_ms) begin
                n_fall  = 1'b0;
                n_armed = 1'b0;
                n_cnt   = '0;
                n_flag  = 1'b0;
            end
        end else begin
            if (i_head.item.impact) begin
                n_armed       = 1'b1;
                n_impact_time = now;
                n_cnt         = '0;
            end
            if (n_armed) begin
                if (i_head.item.still) begin
                    if (n_cnt != COUNT_MAX) begin
                        n_cnt = n_cnt + 8'd1;
                    end
                end else if (n_cnt != '0) begin
                    n_cnt = n_cnt - 8'd1;
                end
                if (n_cnt >= i_cfg.still_count_limit) begin
                    n_fall       = 1'b1;
                    n_latch_time = now;
                    n_armed      = 1'b0;
                    n_cnt        = '0;
                    n_flag       = 1'b1;
                end
                if ((now - n_impact_time) > i_cfg.check_window_ms) begin
                    n_armed = 1'b0;
                    n_cnt   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b0;
            r_fall        <= 1'b0;
            r_cnt         <= '0;
            r_impact_time <= '0;
            r_latch_time  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_armed       <= n_armed;
                r_fall        <= n_fall;
                r_cnt         <= n_cnt;
                r_impact_time <= n_impact_time;
                r_latch_time  <= n_latch_time;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
        if (o_pop) begin
            r_out.fall_flag      <= n_flag;
            r_out.impact_pending <= n_armed;
            r_out.still_level    <= n_cnt;
        end
    end

endmodule

>>> rtl/imu_fall_detector_unit.sv
// Top level of the IMU fall detector: impact followed by stillness.
// Depends on imu_fd_pkg, imu_fd_cfg, imu_fd_front, imu_fd_queue, imu_fd_back.
//
// One result beat per sample beat, in order. A sample can be accepted every
// cycle while the queue has room. A result passes the squaring register, the
// classify step into the 4-entry queue and the state update into the output
// register. The sustained rate of one sample per cycle is set by the state
// update in the back end while the output is not stalled. When the result
// side stalls, the queue absorbs up to four samples before the sample side is
// held off. Configuration writes are always ready and must only be issued
// while no sample is in flight.
module imu_fall_detector_unit import imu_fd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_sample              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_result              o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cfg   cfg;
    t_qpush push;
    t_qhead head;
    logic   pop;

    imu_fd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    imu_fd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_q_count  (head.count),
        .o_push     (push)
    );

    imu_fd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head)
    );

    imu_fd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg       (cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> test/tb_imu_fall_detector_unit.sv
// Self-checking testbench for imu_fall_detector_unit: impact/stillness fall detection.
// Drives sample and register beats, predicts each status beat and compares it in order.
// Depends on imu_fd_pkg and the imu_fall_detector_unit RTL.
`timescale 1ns / 100ps

module tb_imu_fall_detector_unit;
    import imu_fd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(13);
    localparam int LONG_HOLD    = 40;
    localparam int DRAIN_CYCLES = 8;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_sample              in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_result              out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    always #5 clk = ~clk;

    imu_fall_detector_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // detector model state
    t_cfg        det_cfg;
    logic        det_armed;
    logic        det_latched;
    logic [7:0]  det_count;
    logic [31:0] det_impact_t;
    logic [31:0] det_latch_t;

    t_result     status_q[$];
    logic [31:0] stamp = '0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    bit          stall_on = 1'b1;
    int          hold_req_cnt = 0;
    int          err_cnt = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_writes = 0;

    function automatic void reset_detector();
        det_cfg.impact_acc_sq_limit  = RST_IMPACT_ACC;
        det_cfg.impact_rate_sq_limit = RST_IMPACT_RATE;
        det_cfg.still_acc_sq_low     = RST_STILL_LOW;
        det_cfg.still_acc_sq_high    = RST_STILL_HIGH;
        det_cfg.still_rate_sq_limit  = RST_STILL_RATE;
        det_cfg.still_count_limit    = RST_COUNT_LIM;
        det_cfg.check_window_ms      = RST_WINDOW;
        det_cfg.hold_ms              = RST_HOLD;
        det_armed    = 1'b0;
        det_latched  = 1'b0;
        det_count    = '0;
        det_impact_t = '0;
        det_latch_t  = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        case (idx)
            CFG_IMPACT_ACC:  det_cfg.impact_acc_sq_limit  = d;
            CFG_IMPACT_RATE: det_cfg.impact_rate_sq_limit = d;
            CFG_STILL_LOW:   det_cfg.still_acc_sq_low     = d;
            CFG_STILL_HIGH:  det_cfg.still_acc_sq_high    = d;
            CFG_STILL_RATE:  det_cfg.still_rate_sq_limit  = d;
            CFG_COUNT_LIM:   det_cfg.still_count_limit    = d[7:0];
            CFG_WINDOW:      det_cfg.check_window_ms      = d;
            CFG_HOLD:        det_cfg.hold_ms              = d;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] square16(input logic [15:0] v);
        logic [31:0] m;
        m = v[15] ? (32'h0001_0000 - {16'h0000, v}) : {16'h0000, v};
        return m * m;
    endfunction

    function automatic t_result predict_fall_status(input t_sample s);
        logic [31:0] acc_sq;
        logic [31:0] rate_sq;
        logic [31:0] now;
        logic        still;
        t_result     r;
        acc_sq  = square16(s.accel_x) + square16(s.accel_y) + square16(s.accel_z);
        rate_sq = square16(s.rate_x) + square16(s.rate_y) + square16(s.rate_z);
        now     = s.sample_time_ms;
        r       = '0;
        if (det_latched) begin
            r.fall_flag = 1'b1;
            if (now - det_latch_t > det_cfg.hold_ms) begin
                det_latched = 1'b0;
                det_armed   = 1'b0;
                det_count   = '0;
                r.fall_flag = 1'b0;
            end
        end else begin
            if (acc_sq > det_cfg.impact_acc_sq_limit || rate_sq > det_cfg.impact_rate_sq_limit) begin
                det_armed    = 1'b1;
                det_impact_t = now;
                det_count    = '0;
            end
            if (det_armed) begin
                still = acc_sq > det_cfg.still_acc_sq_low && acc_sq < det_cfg.still_acc_sq_high &&
                        rate_sq < det_cfg.still_rate_sq_limit;
                if (still) begin
                    if (det_count < COUNT_MAX) det_count = det_count + 8'd1;
                end else if (det_count > 0) begin
                    det_count = det_count - 8'd1;
                end
                if (det_count >= det_cfg.still_count_limit) begin
                    det_latched = 1'b1;
                    det_latch_t = now;
                    det_armed   = 1'b0;
                    det_count   = '0;
                    r.fall_flag = 1'b1;
                end
                if (now - det_impact_t > det_cfg.check_window_ms) begin
                    det_armed = 1'b0;
                    det_count = '0;
                end
            end
        end
        r.impact_pending = det_armed;
        r.still_level    = det_count;
        return r;
    endfunction

    // random magnitude in [lo, hi] with random sign
    function automatic logic [15:0] spread(input int lo, input int hi);
        int v;
        v = int'($urandom_range(hi, lo));
        if ($urandom_range(0, 1)) v = -v;
        return 16'(v);
    endfunction

    function automatic t_sample make_still();
        t_sample s;
        s = '0;
        s.accel_x = spread(0, 200);
        s.accel_y = spread(0, 200);
        s.accel_z = spread(0, 200);
        s.rate_x  = spread(0, 300);
        s.rate_y  = spread(0, 300);
        s.rate_z  = spread(0, 300);
        case ($urandom_range(0, 2))
            0:       s.accel_x = spread(1700, 2400);
            1:       s.accel_y = spread(1700, 2400);
            default: s.accel_z = spread(1700, 2400);
        endcase
        return s;
    endfunction

    function automatic t_sample make_moving();
        t_sample s;
        s = make_still();
        case ($urandom_range(0, 2))
            0:       s.rate_x = spread(700, 3000);
            1:       s.rate_y = spread(700, 3000);
            default: s.rate_z = spread(700, 3000);
        endcase
        return s;
    endfunction

    function automatic t_sample make_impact();
        t_sample s;
        s = make_still();
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 2))
                0:       s.accel_x = spread(5200, 32768);
                1:       s.accel_y = spread(5200, 32768);
                default: s.accel_z = spread(5200, 32768);
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0:       s.rate_x = spread(4100, 32768);
                1:       s.rate_y = spread(4100, 32768);
                default: s.rate_z = spread(4100, 32768);
            endcase
        end
        return s;
    endfunction

    function automatic t_sample make_noise();
        t_sample s;
        s.accel_x        = 16'($urandom);
        s.accel_y        = 16'($urandom);
        s.accel_z        = 16'($urandom);
        s.rate_x         = 16'($urandom);
        s.rate_y         = 16'($urandom);
        s.rate_z         = 16'($urandom);
        s.sample_time_ms = '0;
        return s;
    endfunction

    function automatic t_sample pick_mixed();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70) return make_still();
        if (r < 85) return make_moving();
        if (r < 93) return make_noise();
        return make_impact();
    endfunction

    function automatic t_cfg near_default_cfg();
        t_cfg c;
        c.impact_acc_sq_limit  = $urandom_range(20000000, 40000000);
        c.impact_rate_sq_limit = $urandom_range(8000000, 30000000);
        c.still_acc_sq_low     = $urandom_range(1500000, 3000000);
        c.still_acc_sq_high    = $urandom_range(5000000, 9000000);
        c.still_rate_sq_limit  = $urandom_range(100000, 800000);
        c.still_count_limit    = 8'($urandom_range(1, 12));
        c.check_window_ms      = $urandom_range(300, 3000);
        c.hold_ms              = $urandom_range(0, 1500);
        return c;
    endfunction

    // called and returns just after a falling edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, d);
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_cfg_all(input t_cfg c);
        cfg_write(CFG_IMPACT_ACC,  c.impact_acc_sq_limit);
        cfg_write(CFG_IMPACT_RATE, c.impact_rate_sq_limit);
        cfg_write(CFG_STILL_LOW,   c.still_acc_sq_low);
        cfg_write(CFG_STILL_HIGH,  c.still_acc_sq_high);
        cfg_write(CFG_STILL_RATE,  c.still_rate_sq_limit);
        cfg_write(CFG_COUNT_LIM,   {24'h0, c.still_count_limit});
        cfg_write(CFG_WINDOW,      c.check_window_ms);
        cfg_write(CFG_HOLD,        c.hold_ms);
    endtask

    // valid stays up across a burst; gaps fall between bursts
    task automatic send_sample(input t_sample s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? int'($urandom_range(0, 6)) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
        status_q.push_back(predict_fall_status(s));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send_after(input int unsigned step, input t_sample s);
        t_sample beat;
        stamp = stamp + step;
        beat = s;
        beat.sample_time_ms = stamp;
        send_sample(beat);
    endtask

    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (status_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic test_directed();
        t_sample s;
        s = '0;
        send_after(0, s);
        s.accel_x = 16'sh7FFF; s.accel_y = 16'sh7FFF; s.accel_z = 16'sh7FFF;
        s.rate_x  = 16'sh7FFF; s.rate_y  = 16'sh7FFF; s.rate_z  = 16'sh7FFF;
        send_after(10, s);
        s.accel_x = 16'sh8000; s.accel_y = 16'sh8000; s.accel_z = 16'sh8000;
        s.rate_x  = 16'sh8000; s.rate_y  = 16'sh8000; s.rate_z  = 16'sh8000;
        send_after(10, s);
        send_after(10, make_still());
        send_after(10, make_moving());
        send_after(10, make_moving());    // count floor at zero
        send_after(2970, make_still());   // window edge, still armed
        send_after(1, make_still());      // window passed
        wait_idle();

        cfg_write(CFG_COUNT_LIM, 32'd3);
        cfg_write(CFG_WINDOW, 32'd1000);
        cfg_write(CFG_HOLD, 32'd200);
        send_after(10, make_impact());
        send_after(10, make_still());
        send_after(10, make_moving());
        send_after(10, make_still());
        send_after(10, make_still());
        send_after(10, make_still());     // confirms
        send_after(100, make_impact());   // ignored while latched
        send_after(100, make_still());    // hold edge
        send_after(1, make_still());      // hold passed
        wait_idle();

        cfg_write(CFG_COUNT_LIM, 32'd0);
        send_after(10, make_impact());    // zero limit confirms at once
        send_after(500, make_noise());
        wait_idle();

        cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_write(CFG_COUNT_LIM, 32'h0000_0102);
        stamp = 32'hFFFF_FFF0;
        send_after(0, make_impact());
        send_after(10, make_still());
        send_after(10, make_still());     // timestamp wraps here
        send_after(150, make_still());
        wait_idle();
    endtask

    task automatic test_count_run();
        t_cfg c;
        c = det_cfg;
        c.still_count_limit = COUNT_MAX;
        c.check_window_ms   = 32'hFFFF_FFFF;
        c.hold_ms           = 32'd0;
        write_cfg_all(c);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        send_after(10, make_impact());
        for (int i = 0; i < 255; i++) begin
            if (i == 128) begin
                gaps_on  = 1'b1;
                stall_on = 1'b1;
            end
            send_after($urandom_range(1, 40), make_still());
        end
        send_after(5, make_still());
        wait_idle();
    endtask

    task automatic test_random_falls();
        int reps;
        for (int seq = 0; seq < 6; seq++) begin
            if (seq % 4 == 0) begin
                wait_idle();
                write_cfg_all(near_default_cfg());
            end
            reps = $urandom_range(0, 2);
            repeat (reps) send_after($urandom_range(5, 60),
                                     $urandom_range(0, 1) ? make_noise() : make_moving());
            send_after($urandom_range(5, 60), make_impact());
            reps = int'(det_cfg.still_count_limit) + int'($urandom_range(0, 5));
            repeat (reps) begin
                if ($urandom_range(0, 19) == 0)
                    send_after(det_cfg.check_window_ms + 1 + $urandom_range(0, 50), pick_mixed());
                else
                    send_after($urandom_range(5, 60), pick_mixed());
            end
            reps = $urandom_range(1, 3);
            repeat (reps) send_after($urandom_range(5, 60), pick_mixed());
            send_after(det_cfg.hold_ms + 1 + $urandom_range(0, 20), pick_mixed());
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_req_cnt++;
        send_after(10, make_impact());
        repeat (24) send_after($urandom_range(5, 60), pick_mixed());
        gaps_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_extremes();
        write_cfg_all('0);
        repeat (15) send_after($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20),
                               make_noise());
        wait_idle();
        write_cfg_all('1);
        repeat (15) send_after($urandom, make_noise());
        wait_idle();
    endtask

    task automatic test_noise();
        t_cfg c;
        repeat (3) begin
            c = '{$urandom, $urandom, $urandom, $urandom, $urandom,
                  8'($urandom_range(0, 255)), $urandom, $urandom};
            write_cfg_all(c);
            repeat (10) send_after($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100),
                                   $urandom_range(0, 1) ? make_noise() : pick_mixed());
            wait_idle();
        end
    endtask

    // output side stall pattern, plus a long hold-off on request
    initial begin : rx_stall
        logic [15:0] pat;
        int          seen;
        int          n;
        pat  = 16'hFFFF;
        seen = 0;
        n    = 0;
        forever begin
            @(negedge clk);
            if (seen != hold_req_cnt) begin
                seen = hold_req_cnt;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (n % 48 == 0) pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            n++;
            pat = {pat[0], pat[15:1]};
            out_ready <= !stall_on || pat[0];
        end
    end

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (status_q.size() == 0) begin
                $error("unexpected result beat %p", out_data);
                err_cnt++;
            end else begin
                want = status_q.pop_front();
                n_checked++;
                if (out_data.fall_flag !== want.fall_flag) begin
                    $error("fall_flag: expected %0d, got %0d", want.fall_flag, out_data.fall_flag);
                    err_cnt++;
                end
                if (out_data.impact_pending !== want.impact_pending) begin
                    $error("impact_pending: expected %0d, got %0d",
                           want.impact_pending, out_data.impact_pending);
                    err_cnt++;
                end
                if (out_data.still_level !== want.still_level) begin
                    $error("still_level: expected %0d, got %0d",
                           want.still_level, out_data.still_level);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_imu_fall_detector_unit failed");
        $finish;
    end

    initial begin
        reset_detector();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_count_run();
        test_random_falls();
        test_backpressure();
        test_extremes();
        test_noise();
        wait_idle();
        if (status_q.size() != 0) begin
            $error("%0d expected results never arrived", status_q.size());
            err_cnt++;
        end
        $display("Run covered %0d samples, %0d checked results, %0d register writes:",
                 n_sent, n_checked, n_writes);
        $display("falls, hold and window expiry, timestamp wrap, extreme settings, long stall.");
        if (err_cnt == 0) begin
            $display("tb_imu_fall_detector_unit passed");
        end else begin
            $display("tb_imu_fall_detector_unit failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/imu_fd_pkg.sv
rtl/imu_fd_cfg.sv
rtl/imu_fd_front.sv
rtl/imu_fd_queue.sv
rtl/imu_fd_back.sv
rtl/imu_fall_detector_unit.sv
test/tb_imu_fall_detector_unit.sv
